### sv/assert_macros.svh
// Assertion macros shared by the bitmap cluster allocator RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

### sv/bca_pkg.sv
// Shared types and constants of the bitmap cluster allocator.
// No dependencies; imported by bca_zero_find, the allocator core and its testbench.
package bca_pkg;

	localparam int unsigned NUM_CLUSTERS_DEF = 1024;
	localparam int unsigned ID_W             = 11;
	localparam int unsigned CMD_W            = 2;
	localparam int unsigned WORD_W           = 32;
	localparam int unsigned POS_W            = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] pos;
	} zf_res_t;

endpackage

### sv/bca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bca_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/bca_zero_find.sv
// First free cluster search within one 32-bit bitmap word.
// Depends on bca_pkg; bits past the last cluster count as used.
module bca_zero_find #(
	parameter int unsigned NUM_CLUSTERS = bca_pkg::NUM_CLUSTERS_DEF,
	parameter int unsigned AW           = 5
) (
	input  logic [bca_pkg::WORD_W-1:0] word,
	input  logic [AW-1:0]              word_idx,
	output bca_pkg::zf_res_t           res
);
	import bca_pkg::*;

	localparam int unsigned WORDS     = (NUM_CLUSTERS + WORD_W - 1) / WORD_W;
	localparam int unsigned LAST_BITS = NUM_CLUSTERS - (WORDS - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	logic [WORD_W-1:0] free_bits;

	always_comb begin
		free_bits = ~word & ((word_idx == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});
		res.found = |free_bits;
		res.pos   = '0;
		// Walk downwards so that the lowest free bit wins.
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				res.pos = POS_W'(i);
			end
		end
	end

endmodule

### sv/bitmap_cluster_allocator_core.sv
// Top level of the bitmap cluster allocator: sequencer, free count and result register.
// Depends on bca_pkg, bca_ram, bca_zero_find and assert_macros.svh.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | command, target_id
//  out     | output    | out_valid/out_stall| cluster_out, ok, was_used, free_left
//
// After reset the bitmap RAM, ceil(NUM_CLUSTERS/32) words deep (32 by default), is cleared
// one 32-bit word a cycle, with in_stall high throughout.
// Allocate passes through IDLE, SCAN and DONE; in SCAN the search unit reads the words in
// turn until a free bit turns up, reading at most ceil(NUM_CLUSTERS/32) words.
// Free and test go IDLE, CHECK, DONE; a rejected id or unused command goes IDLE, DONE.
// One item is in work at a time; a result beat waits in the output register under out_stall
// and a new beat is accepted meanwhile, holding only its completion until the register frees.
`include "assert_macros.svh"

module bitmap_cluster_allocator_core #(
	parameter int unsigned NUM_CLUSTERS = bca_pkg::NUM_CLUSTERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [bca_pkg::CMD_W-1:0]  command,
	input  logic [bca_pkg::ID_W-1:0]   target_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bca_pkg::ID_W-1:0]   cluster_out,
	output logic                       ok,
	output logic                       was_used,
	output logic [bca_pkg::ID_W-1:0]   free_left
);
	import bca_pkg::*;

	localparam int unsigned WORDS = (NUM_CLUSTERS + WORD_W - 1) / WORD_W;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned CW    = $clog2(NUM_CLUSTERS + 1);
	localparam int unsigned CMPW  = (ID_W > CW) ? ID_W : CW;
	localparam int unsigned IW    = AW + POS_W + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	state_t             state_q, state_d;
	logic [AW-1:0]      clr_ptr_q;
	logic [AW-1:0]      scan_ptr_q;
	logic [AW-1:0]      word_q;
	logic [POS_W-1:0]   bit_q;
	logic               is_free_q;
	logic [CW-1:0]      free_count_q;
	logic [ID_W-1:0]    res_cluster_q;
	logic               res_ok_q;
	logic               res_used_q;
	logic               out_valid_q;
	logic [ID_W-1:0]    cluster_out_q;
	logic               ok_q;
	logic               was_used_q;
	logic [ID_W-1:0]    free_left_q;

	logic               in_acc;
	logic               out_load;
	logic               id_ok;
	logic               is_alloc;
	logic               is_ft;
	logic [ID_W-1:0]    id_m1;
	logic               bit_used;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;
	zf_res_t            zf;

	bca_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bca_zero_find #(
		.NUM_CLUSTERS(NUM_CLUSTERS),
		.AW          (AW)
	) u_zero_find (
		.word    (ram_rdata),
		.word_idx(scan_ptr_q),
		.res     (zf)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = !out_valid_q || !out_stall;

	assign id_m1    = target_id - ID_W'(1);
	assign id_ok    = (target_id != '0) && (CMPW'(target_id) <= CMPW'(NUM_CLUSTERS));
	assign is_alloc = (command == CMD_ALLOC);
	assign is_ft    = ((command == CMD_FREE) || (command == CMD_TEST)) && id_ok;
	assign bit_used = ram_rdata[bit_q];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_ptr_q == LAST_WORD) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (is_alloc) begin
						state_d = ST_SCAN;
					end else if (is_ft) begin
						state_d = ST_CHECK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (zf.found || (scan_ptr_q == LAST_WORD)) begin
					state_d = ST_DONE;
				end
			end
			ST_CHECK: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// RAM port control. During the scan the next word is fetched while the current one
	// is searched, so one word is examined per cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_ptr_q;
			end
			ST_IDLE: begin
				if (in_acc && is_alloc) begin
					ram_re = 1'b1;
				end else if (in_acc && is_ft) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(id_m1[ID_W-1:POS_W]);
				end
			end
			ST_SCAN: begin
				if (zf.found) begin
					ram_we    = 1'b1;
					ram_waddr = scan_ptr_q;
					ram_wdata = ram_rdata | (WORD_W'(1) << zf.pos);
				end else if (scan_ptr_q != LAST_WORD) begin
					ram_re    = 1'b1;
					ram_raddr = scan_ptr_q + AW'(1);
				end
			end
			ST_CHECK: begin
				if (is_free_q && bit_used) begin
					ram_we    = 1'b1;
					ram_waddr = word_q;
					ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_q);
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_ptr_q    <= '0;
			free_count_q <= CW'(NUM_CLUSTERS);
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_ptr_q <= clr_ptr_q + AW'(1);
			end
			if ((state_q == ST_SCAN) && zf.found) begin
				free_count_q <= free_count_q - CW'(1);
			end else if ((state_q == ST_CHECK) && is_free_q && bit_used) begin
				free_count_q <= free_count_q + CW'(1);
			end
			if ((state_q == ST_DONE) && out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			scan_ptr_q    <= '0;
			word_q        <= AW'(id_m1[ID_W-1:POS_W]);
			bit_q         <= id_m1[POS_W-1:0];
			is_free_q     <= (command == CMD_FREE);
			res_cluster_q <= '0;
			res_ok_q      <= 1'b0;
			res_used_q    <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			if (zf.found) begin
				res_cluster_q <= ID_W'(IW'({scan_ptr_q, zf.pos}) + IW'(1));
				res_ok_q      <= 1'b1;
			end else begin
				scan_ptr_q <= scan_ptr_q + AW'(1);
			end
		end
		if (state_q == ST_CHECK) begin
			res_ok_q   <= 1'b1;
			res_used_q <= bit_used;
		end
		if ((state_q == ST_DONE) && out_load) begin
			cluster_out_q <= res_cluster_q;
			ok_q          <= res_ok_q;
			was_used_q    <= res_used_q;
			free_left_q   <= ID_W'(free_count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign cluster_out = cluster_out_q;
	assign ok          = ok_q;
	assign was_used    = was_used_q;
	assign free_left   = free_left_q;

	`ASSERT_CLK(a_free_count_range, clk, arst_n, free_count_q <= CW'(NUM_CLUSTERS), "free count above cluster total")
	`ASSERT_CLK(a_free_count_step, clk, arst_n, (free_count_q == $past(free_count_q)) || (free_count_q == CW'($past(free_count_q) + 1'b1)) || (free_count_q == CW'($past(free_count_q) - 1'b1)), "free count moved by more than one")
	`ASSERT_NEVER(a_ram_collision, clk, arst_n, ram_we && ram_re && (ram_waddr == ram_raddr), "bitmap word read and written together")
	`ASSERT_CLK(a_alloc_beat, clk, arst_n, (out_valid_q && (cluster_out_q != '0)) |-> (ok_q && !was_used_q), "allocation beat without success")

endmodule

### tb/tb_bitmap_cluster_allocator_core.sv
// Self-checking testbench for bitmap_cluster_allocator_core, with a scoreboard class that
// tracks the bitmap and the free count. Depends on bca_pkg and on the allocator RTL.
`timescale 1ns / 100ps

import bca_pkg::*;

typedef struct packed {
	logic [ID_W-1:0] cluster;
	logic            ok;
	logic            was_used;
	logic [ID_W-1:0] free_left;
} alloc_result_t;

localparam int unsigned        TB_CLUSTERS = NUM_CLUSTERS_DEF;
localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;
localparam int unsigned        REPORT_MAX  = 10;

class alloc_scoreboard;
	bit            used_map [TB_CLUSTERS];
	int unsigned   free_total;
	alloc_result_t expected_q [$];
	int unsigned   fails;
	int unsigned   beats_seen;

	function new();
		foreach (used_map[i])
			used_map[i] = 1'b0;
		free_total = TB_CLUSTERS;
		fails = 0;
		beats_seen = 0;
	endfunction

	// Applies one accepted command to the bitmap copy and queues the beat it should produce.
	function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
		alloc_result_t exp;
		bit            found;
		exp = '0;
		found = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				for (int b = 0; b < TB_CLUSTERS && !found; b++) begin
					if (!used_map[b]) begin
						used_map[b] = 1'b1;
						free_total--;
						exp.cluster = ID_W'(b + 1);
						exp.ok = 1'b1;
						found = 1'b1;
					end
				end
			end
			CMD_FREE, CMD_TEST: begin
				if (id != 0 && id <= TB_CLUSTERS) begin
					exp.was_used = used_map[id - 1];
					exp.ok = 1'b1;
					if (cmd == CMD_FREE && exp.was_used) begin
						used_map[id - 1] = 1'b0;
						free_total++;
					end
				end
			end
			default: begin
			end
		endcase
		exp.free_left = free_total[ID_W-1:0];
		expected_q.push_back(exp);
	endfunction

	function void check_result(alloc_result_t got);
		alloc_result_t exp;
		beats_seen++;
		if (expected_q.size() == 0) begin
			if (fails < REPORT_MAX)
				$display("unexpected result beat %0d: cluster_out=%0d ok=%0b was_used=%0b %s%0d",
					beats_seen, got.cluster, got.ok, got.was_used, "free_left=",
					got.free_left);
			fails++;
			return;
		end
		exp = expected_q.pop_front();
		if (got.cluster !== exp.cluster || got.ok !== exp.ok ||
				got.was_used !== exp.was_used || got.free_left !== exp.free_left) begin
			if (fails < REPORT_MAX) begin
				$display("result beat %0d mismatch: expected cluster_out=%0d ok=%0b %s%0b %s%0d",
					beats_seen, exp.cluster, exp.ok, "was_used=", exp.was_used,
					"free_left=", exp.free_left);
				$display("  got cluster_out=%0d ok=%0b was_used=%0b free_left=%0d",
					got.cluster, got.ok, got.was_used, got.free_left);
			end
			fails++;
		end
	endfunction
endclass

module tb_bitmap_cluster_allocator_core;

	localparam int unsigned RANDOM_BEATS = 1600;
	localparam int unsigned IDLE_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES  = 40;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [CMD_W-1:0] command;
	logic [ID_W-1:0]  target_id;
	logic             out_valid;
	logic             out_stall;
	logic [ID_W-1:0]  cluster_out;
	logic             ok;
	logic             was_used;
	logic [ID_W-1:0]  free_left;

	alloc_scoreboard  sb = new();
	bit               in_calm = 1'b0;
	bit               out_calm = 1'b0;
	int unsigned      idle_cycles = 0;

	bitmap_cluster_allocator_core #(
		.NUM_CLUSTERS(TB_CLUSTERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.target_id(target_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cluster_out(cluster_out),
		.ok(ok),
		.was_used(was_used),
		.free_left(free_left)
	);

	always #1 clk = ~clk;

	// Wait before a beat; now and then a side switches into a stretch with no idling at all.
	function automatic int unsigned draw_wait(inout bit calm);
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return ID_W'($urandom_range(TB_CLUSTERS + 1, (1 << ID_W) - 1));
		if (r == 2)
			return ID_W'(TB_CLUSTERS);
		return ID_W'($urandom_range(1, TB_CLUSTERS));
	endfunction

	// While filling, allocation dominates so that the map reaches full; afterwards frees and
	// allocations balance around a nearly full map.
	function automatic logic [CMD_W-1:0] pick_command(bit filling);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (filling) begin
			if (r < 90)
				return CMD_ALLOC;
			if (r < 94)
				return CMD_FREE;
			if (r < 98)
				return CMD_TEST;
			return CMD_UNUSED;
		end
		if (r < 35)
			return CMD_ALLOC;
		if (r < 75)
			return CMD_FREE;
		if (r < 95)
			return CMD_TEST;
		return CMD_UNUSED;
	endfunction

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
		int unsigned gap;
		gap = draw_wait(in_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		target_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_command(cmd, id);
	endtask

	// Result side: stall for a drawn number of cycles, then take the next beat.
	initial begin
		int unsigned hold;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(out_calm);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			sb.check_result({cluster_out, ok, was_used, free_left});
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		bit filling;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_ALLOC;
		target_id <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats: range edges of the id, every command, repeated and rejected frees.
		send_beat(CMD_ALLOC, '1);
		send_beat(CMD_ALLOC, '0);
		send_beat(CMD_TEST, ID_W'(1));
		send_beat(CMD_TEST, ID_W'(3));
		send_beat(CMD_TEST, '0);
		send_beat(CMD_FREE, '0);
		send_beat(CMD_TEST, ID_W'(TB_CLUSTERS));
		send_beat(CMD_TEST, ID_W'(TB_CLUSTERS + 1));
		send_beat(CMD_FREE, '1);
		send_beat(CMD_FREE, ID_W'(1));
		send_beat(CMD_FREE, ID_W'(1));
		send_beat(CMD_ALLOC, ID_W'(1));
		send_beat(CMD_UNUSED, '0);
		send_beat(CMD_UNUSED, '1);
		send_beat(CMD_FREE, ID_W'(TB_CLUSTERS));
		send_beat(CMD_TEST, ID_W'(2));
		send_beat(CMD_ALLOC, ID_W'(TB_CLUSTERS));
		send_beat(CMD_TEST, ID_W'(TB_CLUSTERS + 1));

		filling = 1'b1;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (sb.free_total == 0)
				filling = 1'b0;
			send_beat(pick_command(filling), pick_id());
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
